>>> hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication, checked at every rising clock edge outside reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hdl/nbc_pkg.sv
// Shared types, constants and counter functions of the bigram counter.
package nbc_pkg;

    localparam int COUNT_BITS  = 32;
    localparam int VALUE_W     = 32;
    localparam int CHAR_W      = 8;
    localparam int IDX_W       = 5;
    localparam int NUM_BASES   = 4;
    localparam int NUM_PAIRS   = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [IDX_W-1:0] IDX_FIRST_PAIR = IDX_W'(NUM_BASES);
    localparam logic [IDX_W-1:0] IDX_LINES      = IDX_W'(NUM_BASES + NUM_PAIRS);

    localparam logic [CHAR_W-1:0] CHAR_A       = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_C       = 8'h43;
    localparam logic [CHAR_W-1:0] CHAR_G       = 8'h47;
    localparam logic [CHAR_W-1:0] CHAR_T       = 8'h54;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'd32;

    localparam logic [1:0] CODE_A = 2'd0;
    localparam logic [1:0] CODE_C = 2'd1;
    localparam logic [1:0] CODE_G = 2'd2;
    localparam logic [1:0] CODE_T = 2'd3;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef logic [COUNT_BITS-1:0] count_t;

    typedef enum logic [1:0] {
        OP_CHAR   = 2'd0,
        OP_EOL    = 2'd1,
        OP_REPORT = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic {
        BK_RUN,
        BK_REPORT
    } back_state_t;

    typedef struct packed {
        op_t        op;
        logic       cur_valid;
        logic [1:0] cur_code;
        logic       pair_valid;
        logic [3:0] pair_idx;
        logic       line_ok;
    } cmd_t;

    function automatic logic [CHAR_W-1:0] fold_upper(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
        begin
            r = c - CASE_OFFSET;
        end
        return r;
    endfunction

    function automatic logic is_base(input logic [CHAR_W-1:0] c);
        return (c == CHAR_A) || (c == CHAR_C) || (c == CHAR_G) || (c == CHAR_T);
    endfunction

    function automatic logic [1:0] base_code(input logic [CHAR_W-1:0] c);
        logic [1:0] r;
        r = CODE_A;
        if (c == CHAR_C)
        begin
            r = CODE_C;
        end
        else if (c == CHAR_G)
        begin
            r = CODE_G;
        end
        else if (c == CHAR_T)
        begin
            r = CODE_T;
        end
        return r;
    endfunction

    function automatic count_t sat_add(input count_t a, input count_t b);
        logic [COUNT_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COUNT_BITS] ? COUNT_MAX : s[COUNT_BITS-1:0];
    endfunction

    function automatic count_t sat_inc(input count_t a);
        return (a == COUNT_MAX) ? COUNT_MAX : a + count_t'(1);
    endfunction

    function automatic logic [VALUE_W-1:0] clip_value(input count_t v);
        logic [COUNT_BITS+VALUE_W-1:0] wide;
        wide = {{VALUE_W{1'b0}}, v};
        if (wide[COUNT_BITS+VALUE_W-1:VALUE_W] != '0)
        begin
            return {VALUE_W{1'b1}};
        end
        return wide[VALUE_W-1:0];
    endfunction

endpackage

>>> hdl/nucleotide_bigram_counter.sv
// Top level of the nucleotide bigram counter: front end, queue and back end.
//
// Input stream (s_*): one item per handshake. s_tuser carries the op
// (character, end of line, report, clear) and s_tdata the raw byte.
// Characters and end-of-line items are taken one per cycle while the queue is
// not full: the front end classifies each byte in the accept cycle, a
// four-entry queue holds the command, and the back end updates the pending
// counters or commits a well-formed line into the saturating totals.
// A report item yields 21 results on the output stream (m_*): m_tuser is the
// counter index, m_tdata the count, m_tlast marks index 20. m_tvalid rises
// once the report has passed the queue, the sequencer state register and the
// output register, then one result per cycle while m_tready is high; the
// report sequencer holds the queue until all 21 results are loaded, so
// input keeps flowing until the queue fills. When the receiver stalls,
// the output register holds its result and the sequencer waits; s_tready
// drops once the queue is full. Reset clears every total, every pending
// count and the line state at once; the block is ready straight out of reset.
module nucleotide_bigram_counter
    import nbc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [CHAR_W-1:0]  s_tdata,   // [7:0] char_code
    input  logic [1:0]         s_tuser,   // [1:0] op
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [VALUE_W-1:0] m_tdata,   // [31:0] count_value
    output logic [IDX_W-1:0]   m_tuser,   // [4:0] counter_index
    output logic               m_tlast
);

    logic push;
    logic pop;
    logic queue_full;
    logic queue_empty;
    cmd_t push_cmd;
    cmd_t head;

    nbc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_op      (s_tuser),
        .in_char    (s_tdata),
        .queue_full (queue_full),
        .in_ready   (s_tready),
        .push       (push),
        .cmd        (push_cmd)
    );

    nbc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .full     (queue_full),
        .empty    (queue_empty),
        .head     (head)
    );

    nbc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .head        (head),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_index   (m_tuser),
        .out_value   (m_tdata),
        .out_last    (m_tlast)
    );

endmodule

>>> hdl/nbc_front.sv
// Front end: accepts items, folds case, classifies bases and tracks line state.
module nbc_front
    import nbc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [1:0]        in_op,
    input  logic [CHAR_W-1:0] in_char,
    input  logic              queue_full,
    output logic              in_ready,
    output logic              push,
    output cmd_t              cmd
);

    logic       line_started_reg, line_started_next;
    logic       line_bad_reg,     line_bad_next;
    logic       prev_base_reg,    prev_base_next;
    logic [1:0] prev_code_reg,    prev_code_next;

    logic [CHAR_W-1:0] ch;
    logic              cur_base;
    logic [1:0]        cur_code;
    op_t               op;

    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full;
    assign op       = op_t'(in_op);
    assign ch       = fold_upper(in_char);
    assign cur_base = is_base(ch);
    assign cur_code = base_code(ch);

    always_comb
    begin
        cmd               = '0;
        cmd.op            = op;
        line_started_next = line_started_reg;
        line_bad_next     = line_bad_reg;
        prev_base_next    = prev_base_reg;
        prev_code_next    = prev_code_reg;
        unique case (op)
            OP_CHAR:
            begin
                cmd.cur_valid     = cur_base;
                cmd.cur_code      = cur_code;
                cmd.pair_valid    = cur_base && line_started_reg && prev_base_reg;
                cmd.pair_idx      = {prev_code_reg, cur_code};
                line_bad_next     = line_bad_reg || (line_started_reg && !prev_base_reg);
                prev_base_next    = cur_base;
                prev_code_next    = cur_code;
                line_started_next = 1'b1;
            end
            OP_EOL, OP_CLEAR:
            begin
                cmd.line_ok       = line_started_reg && !line_bad_reg;
                line_started_next = 1'b0;
                line_bad_next     = 1'b0;
                prev_base_next    = 1'b0;
                prev_code_next    = CODE_A;
            end
            OP_REPORT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_started_reg <= 1'b0;
            line_bad_reg     <= 1'b0;
            prev_base_reg    <= 1'b0;
            prev_code_reg    <= CODE_A;
        end
        else if (push)
        begin
            line_started_reg <= line_started_next;
            line_bad_reg     <= line_bad_next;
            prev_base_reg    <= prev_base_next;
            prev_code_reg    <= prev_code_next;
        end
    end

endmodule

>>> hdl/nbc_queue.sv
// Short command queue between the front end and the counter back end.
module nbc_queue
    import nbc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic full,
    output logic empty,
    output cmd_t head
);

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

>>> hdl/nbc_back.sv
// Back end: pending and total counters, line commit and report sequencer.
module nbc_back
    import nbc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               queue_empty,
    input  cmd_t               head,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [IDX_W-1:0]   out_index,
    output logic [VALUE_W-1:0] out_value,
    output logic               out_last
);

    back_state_t state_reg, state_next;

    count_t pend_base_reg [NUM_BASES];
    count_t pend_pair_reg [NUM_PAIRS];
    count_t base_tot_reg  [NUM_BASES];
    count_t pair_tot_reg  [NUM_PAIRS];
    count_t line_tot_reg;

    logic [IDX_W-1:0]   idx_reg;
    logic               out_valid_reg;
    logic [IDX_W-1:0]   out_index_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic               out_last_reg;

    logic               load;
    logic [IDX_W-1:0]   pair_sel;
    count_t             report_value;

    assign out_valid = out_valid_reg;
    assign out_index = out_index_reg;
    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_RUN:
            begin
                if (!queue_empty && head.op == OP_REPORT)
                begin
                    state_next = BK_REPORT;
                end
            end
            BK_REPORT:
            begin
                if ((!out_valid_reg || out_ready) && idx_reg == IDX_LINES)
                begin
                    state_next = BK_RUN;
                end
            end
            default:
            begin
                state_next = BK_RUN;
            end
        endcase
    end

    always_comb
    begin
        pop  = 1'b0;
        load = 1'b0;
        unique case (state_reg)
            BK_RUN:
            begin
                pop = !queue_empty;
            end
            BK_REPORT:
            begin
                load = !out_valid_reg || out_ready;
            end
            default:
            begin
            end
        endcase
    end

    assign pair_sel = idx_reg - IDX_FIRST_PAIR;

    always_comb
    begin
        if (idx_reg < IDX_FIRST_PAIR)
        begin
            report_value = base_tot_reg[idx_reg[1:0]];
        end
        else if (idx_reg < IDX_LINES)
        begin
            report_value = pair_tot_reg[pair_sel[3:0]];
        end
        else
        begin
            report_value = line_tot_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_RUN;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            line_tot_reg  <= '0;
            for (int i = 0; i < NUM_BASES; i++)
            begin
                pend_base_reg[i] <= '0;
                base_tot_reg[i]  <= '0;
            end
            for (int i = 0; i < NUM_PAIRS; i++)
            begin
                pend_pair_reg[i] <= '0;
                pair_tot_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= (idx_reg == IDX_LINES) ? '0 : idx_reg + IDX_W'(1);
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (pop)
            begin
                unique case (head.op)
                    OP_CHAR:
                    begin
                        for (int i = 0; i < NUM_BASES; i++)
                        begin
                            if (head.cur_valid && head.cur_code == 2'(i))
                            begin
                                pend_base_reg[i] <= sat_inc(pend_base_reg[i]);
                            end
                        end
                        for (int i = 0; i < NUM_PAIRS; i++)
                        begin
                            if (head.pair_valid && head.pair_idx == 4'(i))
                            begin
                                pend_pair_reg[i] <= sat_inc(pend_pair_reg[i]);
                            end
                        end
                    end
                    OP_EOL:
                    begin
                        for (int i = 0; i < NUM_BASES; i++)
                        begin
                            pend_base_reg[i] <= '0;
                            if (head.line_ok)
                            begin
                                base_tot_reg[i] <= sat_add(base_tot_reg[i], pend_base_reg[i]);
                            end
                        end
                        for (int i = 0; i < NUM_PAIRS; i++)
                        begin
                            pend_pair_reg[i] <= '0;
                            if (head.line_ok)
                            begin
                                pair_tot_reg[i] <= sat_add(pair_tot_reg[i], pend_pair_reg[i]);
                            end
                        end
                        if (head.line_ok)
                        begin
                            line_tot_reg <= sat_inc(line_tot_reg);
                        end
                    end
                    OP_REPORT:
                    begin
                    end
                    OP_CLEAR:
                    begin
                        line_tot_reg <= '0;
                        for (int i = 0; i < NUM_BASES; i++)
                        begin
                            pend_base_reg[i] <= '0;
                            base_tot_reg[i]  <= '0;
                        end
                        for (int i = 0; i < NUM_PAIRS; i++)
                        begin
                            pend_pair_reg[i] <= '0;
                            pair_tot_reg[i]  <= '0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_index_reg <= idx_reg;
            out_value_reg <= clip_value(report_value);
            out_last_reg  <= (idx_reg == IDX_LINES);
        end
    end

endmodule

>>> hdl/nbc_checker.sv
// Port-level checker for the nucleotide bigram counter, bound to the top level.
`include "assert_macros.svh"

module nbc_checker
    import nbc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [VALUE_W-1:0] m_tdata,
    input logic [IDX_W-1:0]   m_tuser,
    input logic               m_tlast
);

    logic             out_fire;
    logic             out_stall;
    logic [IDX_W-1:0] next_idx_reg;

    assign out_fire  = m_tvalid && m_tready;
    assign out_stall = m_tvalid && !m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_idx_reg <= '0;
        end
        else
        begin
            next_idx_reg <= m_tuser + IDX_W'(1);
        end
    end

    `ASSERT_SAME(a_last_marks_lines, clk, rst_n, m_tvalid, m_tlast == (m_tuser == IDX_LINES))
    `ASSERT_NEXT(a_index_steps, clk, rst_n, out_fire && !m_tlast, !m_tvalid || m_tuser == next_idx_reg)
    `ASSERT_NEXT(a_output_holds, clk, rst_n, out_stall, m_tvalid && $stable({m_tdata, m_tuser}))

endmodule

bind nucleotide_bigram_counter nbc_checker u_nbc_checker (.*);

>>> tb/tb.sv
// Self-checking stream testbench for the nucleotide bigram counter.
module tb;
    import nbc_pkg::*;

    localparam int NUM_COUNTERS   = NUM_BASES + NUM_PAIRS + 1;
    localparam int RANDOM_ITEMS   = 420;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int TAIL_CYCLES    = 30;
    localparam int MAX_PRINTED    = 30;

    typedef struct {
        op_t              op;
        logic [CHAR_W-1:0] ch;
    } stim_t;

    typedef struct {
        logic [IDX_W-1:0]   idx;
        logic [VALUE_W-1:0] value;
        logic               is_last;
    } tally_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [CHAR_W-1:0]  s_tdata = '0;
    logic [1:0]         s_tuser = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [VALUE_W-1:0] m_tdata;
    logic [IDX_W-1:0]   m_tuser;
    logic               m_tlast;

    logic               s_fire = 1'b0;
    logic               calm = 1'b0;
    int                 idle_cycles = 0;
    int                 mismatches = 0;
    int                 n_queued = 0;
    int                 n_taken = 0;
    int                 n_reports = 0;
    int                 n_results = 0;

    stim_t  feed_q[$];
    tally_t due_tallies[$];

    count_t            base_sum[NUM_BASES];
    count_t            pair_sum[NUM_PAIRS];
    count_t            line_sum;
    count_t            open_bases[NUM_BASES];
    count_t            open_pairs[NUM_PAIRS];
    logic [CHAR_W-1:0] prev_byte;
    logic              line_open;
    logic              line_broken;

    nucleotide_bigram_counter dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic count_t plus_sat(input count_t a, input count_t b);
        if (a > COUNT_MAX - b)
        begin
            return COUNT_MAX;
        end
        return a + b;
    endfunction

    function automatic int base_of(input logic [CHAR_W-1:0] c);
        case (c)
            CHAR_A: return 0;
            CHAR_C: return 1;
            CHAR_G: return 2;
            CHAR_T: return 3;
            default: return -1;
        endcase
    endfunction

    task automatic drop_open_line();
        for (int i = 0; i < NUM_BASES; i++)
        begin
            open_bases[i] = '0;
        end
        for (int i = 0; i < NUM_PAIRS; i++)
        begin
            open_pairs[i] = '0;
        end
        prev_byte = '0;
        line_open = 1'b0;
        line_broken = 1'b0;
    endtask

    task automatic zero_totals();
        for (int i = 0; i < NUM_BASES; i++)
        begin
            base_sum[i] = '0;
        end
        for (int i = 0; i < NUM_PAIRS; i++)
        begin
            pair_sum[i] = '0;
        end
        line_sum = '0;
        drop_open_line();
    endtask

    task automatic tally_item(input op_t op, input logic [CHAR_W-1:0] raw);
        logic [CHAR_W-1:0] ch;
        int                cur;
        int                prev;
        tally_t            t;
        count_t            v;

        ch = raw;
        if (raw >= CHAR_LOWER_A && raw <= CHAR_LOWER_Z)
        begin
            ch = raw - CASE_OFFSET;
        end
        case (op)
            OP_CHAR:
            begin
                cur = base_of(ch);
                prev = base_of(prev_byte);
                if (line_open && prev < 0)
                begin
                    line_broken = 1'b1;
                end
                if (cur >= 0)
                begin
                    open_bases[cur] = plus_sat(open_bases[cur], count_t'(1));
                    if (line_open && prev >= 0)
                    begin
                        open_pairs[prev * 4 + cur] =
                            plus_sat(open_pairs[prev * 4 + cur], count_t'(1));
                    end
                end
                prev_byte = ch;
                line_open = 1'b1;
            end
            OP_EOL:
            begin
                if (line_open && !line_broken)
                begin
                    for (int i = 0; i < NUM_BASES; i++)
                    begin
                        base_sum[i] = plus_sat(base_sum[i], open_bases[i]);
                    end
                    for (int i = 0; i < NUM_PAIRS; i++)
                    begin
                        pair_sum[i] = plus_sat(pair_sum[i], open_pairs[i]);
                    end
                    line_sum = plus_sat(line_sum, count_t'(1));
                end
                drop_open_line();
            end
            OP_REPORT:
            begin
                n_reports++;
                for (int i = 0; i < NUM_COUNTERS; i++)
                begin
                    if (i < NUM_BASES)
                    begin
                        v = base_sum[i];
                    end
                    else if (i < NUM_BASES + NUM_PAIRS)
                    begin
                        v = pair_sum[i - NUM_BASES];
                    end
                    else
                    begin
                        v = line_sum;
                    end
                    t.idx = IDX_W'(i);
                    t.value = VALUE_W'(v);
                    t.is_last = (i == NUM_COUNTERS - 1);
                    due_tallies.push_back(t);
                end
            end
            default:
            begin
                zero_totals();
            end
        endcase
    endtask

    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
        begin
            $display("MISMATCH at %0t: %s", $time, what);
        end
    endtask

    task automatic push_item(input op_t op, input logic [CHAR_W-1:0] ch);
        stim_t s;
        s.op = op;
        s.ch = ch;
        feed_q.push_back(s);
        n_queued++;
    endtask

    function automatic logic [CHAR_W-1:0] pick_base();
        logic [CHAR_W-1:0] b;
        case ($urandom_range(0, 3))
            0: b = CHAR_A;
            1: b = CHAR_C;
            2: b = CHAR_G;
            default: b = CHAR_T;
        endcase
        if ($urandom_range(0, 1) == 1)
        begin
            b = b + CASE_OFFSET;
        end
        return b;
    endfunction

    task automatic push_bases(input int n);
        for (int i = 0; i < n; i++)
        begin
            push_item(OP_CHAR, pick_base());
        end
    endtask

    task automatic build_stimulus();
        int kind;

        // directed: zero report, mixed-case line, empty line, odd last byte,
        // broken line, non-ASCII bytes, report with an open line, clear
        push_item(OP_REPORT, 8'h00);
        push_item(OP_CHAR, CHAR_A);
        push_item(OP_CHAR, CHAR_C + CASE_OFFSET);
        push_item(OP_CHAR, CHAR_G + CASE_OFFSET);
        push_item(OP_CHAR, CHAR_T);
        push_item(OP_EOL, 8'hFF);
        push_item(OP_EOL, 8'h00);
        push_item(OP_CHAR, CHAR_G);
        push_item(OP_CHAR, CHAR_G);
        push_item(OP_CHAR, 8'hFF);
        push_item(OP_EOL, 8'h00);
        push_item(OP_CHAR, CHAR_A);
        push_item(OP_CHAR, 8'h00);
        push_item(OP_CHAR, CHAR_C);
        push_item(OP_EOL, 8'h00);
        push_item(OP_CHAR, CHAR_T);
        push_item(OP_CHAR, CHAR_A + CASE_OFFSET);
        push_item(OP_REPORT, 8'hFF);
        push_item(OP_EOL, 8'h00);
        push_item(OP_REPORT, 8'h00);
        push_item(OP_CLEAR, 8'hFF);
        push_item(OP_REPORT, 8'h00);

        while (n_queued < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 55)
            begin
                push_bases($urandom_range(0, 10));
                push_item(OP_EOL, CHAR_W'($urandom_range(0, 255)));
            end
            else if (kind < 70)
            begin
                push_bases($urandom_range(0, 8));
                push_item(OP_CHAR, CHAR_W'($urandom_range(0, 255)));
                push_item(OP_EOL, CHAR_W'($urandom_range(0, 255)));
            end
            else if (kind < 85)
            begin
                push_bases($urandom_range(0, 4));
                push_item(OP_CHAR, CHAR_W'($urandom_range(0, 255)));
                push_bases($urandom_range(1, 4));
                push_item(OP_EOL, CHAR_W'($urandom_range(0, 255)));
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    push_item(op_t'($urandom_range(0, 1)), CHAR_W'($urandom_range(0, 255)));
                end
            end
            if ($urandom_range(0, 99) < 12)
            begin
                push_item(OP_REPORT, CHAR_W'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 99) < 2)
            begin
                push_item(OP_CLEAR, CHAR_W'($urandom_range(0, 255)));
            end
        end
        push_item(OP_REPORT, CHAR_W'($urandom_range(0, 255)));
    endtask

    always @(negedge clk)
    begin : drive_inputs
        stim_t s;
        if (!s_tvalid || s_fire)
        begin
            if (feed_q.size() > 0 && (calm || $urandom_range(0, 99) >= 30))
            begin
                s = feed_q.pop_front();
                s_tuser <= s.op;
                s_tdata <= s.ch;
                s_tvalid <= 1'b1;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= rst_n && (calm || $urandom_range(0, 99) >= 30);
        calm <= (n_taken >= 200 && n_taken < 300);
    end

    always @(posedge clk)
    begin : watch_outputs
        tally_t t;
        s_fire <= rst_n && s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
        begin
            tally_item(op_t'(s_tuser), s_tdata);
            n_taken++;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            n_results++;
            if (due_tallies.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected result index %0d value %0d",
                                        m_tuser, m_tdata));
            end
            else
            begin
                t = due_tallies.pop_front();
                if (m_tuser !== t.idx)
                begin
                    flag_mismatch($sformatf("index %0d, want %0d", m_tuser, t.idx));
                end
                if (m_tdata !== t.value)
                begin
                    flag_mismatch($sformatf("count at index %0d is %0d, want %0d",
                                            t.idx, m_tdata, t.value));
                end
                if (m_tlast !== t.is_last)
                begin
                    flag_mismatch($sformatf("tlast at index %0d is %b, want %b",
                                            t.idx, m_tlast, t.is_last));
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout after %0d cycles with no transfer", idle_cycles);
            $display("Some tests failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        zero_totals();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        build_stimulus();
        do
        begin
            @(posedge clk);
        end
        while (feed_q.size() != 0 || s_tvalid || due_tallies.size() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (due_tallies.size() != 0)
        begin
            flag_mismatch($sformatf("%0d results never arrived", due_tallies.size()));
        end
        $display("Sent %0d items (characters, line ends, reports, clears), %0d reports",
                 n_taken, n_reports);
        $display("Checked %0d counter results, %0d lines committed since last clear",
                 n_results, line_sum);
        if (mismatches == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
